// ===== hw/rtl/mos_pkg.sv =====
// Shared constants for the median-of-samples block.
package mos_pkg;

    // Number of sample fields carried by one input word.
    localparam int FIELD_COUNT = 8;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_STACKS  = 8;
    localparam int DEF_SAMPLE_BITS = 16;

    // Stack count register.
    localparam int          CFG_BITS          = 4;
    localparam logic [3:0]  STACK_COUNT_RESET = 4'd8;

endpackage

// ===== hw/rtl/mos_lane.sv =====
// One lane: ranks its own sample among the samples in use and registers the rank.
module mos_lane #(
    parameter int LANES       = mos_pkg::DEF_MAX_STACKS,
    parameter int LANE_IDX    = 0,
    parameter int SAMPLE_BITS = mos_pkg::DEF_SAMPLE_BITS,
    parameter int CNT_W       = 4
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [SAMPLE_BITS-1:0] i_samples [mos_pkg::FIELD_COUNT],
    input  logic [CNT_W-1:0]       i_count,
    output logic [CNT_W-1:0]       o_rank,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic                   o_used
);

    logic [CNT_W-1:0]       r_rank;
    logic [SAMPLE_BITS-1:0] r_value;
    logic                   r_used;
    logic [CNT_W-1:0]       n_rank;

    // Equal samples are ordered by lane index, so every used lane gets a
    // distinct rank from zero to count minus one.
    always_comb begin
        n_rank = '0;
        for (int j = 0; j < LANES; j++) begin
            if (j != LANE_IDX && CNT_W'(j) < i_count) begin
                if (i_samples[j] < i_samples[LANE_IDX] ||
                    (i_samples[j] == i_samples[LANE_IDX] && j < LANE_IDX)) begin
                    n_rank = n_rank + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rank  <= n_rank;
            r_value <= i_samples[LANE_IDX];
            r_used  <= (CNT_W'(LANE_IDX) < i_count);
        end
    end

    assign o_rank  = r_rank;
    assign o_value = r_value;
    assign o_used  = r_used;

endmodule

// ===== hw/rtl/mos_merge.sv =====
// Merge stage: picks the middle-ranked lanes and adds them into the registered median.
module mos_merge #(
    parameter int LANES       = mos_pkg::DEF_MAX_STACKS,
    parameter int SAMPLE_BITS = mos_pkg::DEF_SAMPLE_BITS,
    parameter int CNT_W       = 4
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [CNT_W-1:0]       i_count,
    input  logic [CNT_W-1:0]       i_rank  [LANES],
    input  logic [SAMPLE_BITS-1:0] i_value [LANES],
    input  logic [LANES-1:0]       i_used,
    output logic [SAMPLE_BITS:0]   o_median
);

    logic [SAMPLE_BITS:0]   r_median;
    logic [SAMPLE_BITS:0]   n_median;
    logic [CNT_W-1:0]       w_k_lo;
    logic [CNT_W-1:0]       w_k_hi;
    logic [SAMPLE_BITS-1:0] w_lo;
    logic [SAMPLE_BITS-1:0] w_hi;

    // With an odd count both picks land on the same lane, which doubles it.
    assign w_k_lo = (i_count - CNT_W'(1)) >> 1;
    assign w_k_hi = i_count >> 1;

    always_comb begin
        w_lo = '0;
        w_hi = '0;
        for (int i = 0; i < LANES; i++) begin
            if (i_used[i] && i_rank[i] == w_k_lo) begin
                w_lo = w_lo | i_value[i];
            end
            if (i_used[i] && i_rank[i] == w_k_hi) begin
                w_hi = w_hi | i_value[i];
            end
        end
        if (i_count == '0) begin
            n_median = '0;
        end else begin
            n_median = {1'b0, w_lo} + {1'b0, w_hi};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_median <= n_median;
        end
    end

    assign o_median = r_median;

endmodule

// ===== hw/rtl/median_of_samples.sv =====
// Top level of the median-of-samples block: lanes, merge stage and handshake control.
//
// Takes one word of up to eight voxel samples every clock cycle while the input is not
// stalled and returns the median of the first stack_count of them, in units of half
// an input step (an odd count gives twice the middle sample, an even count the sum
// of the two middle samples, a count of zero gives zero). Each word passes the lane
// stage, where each lane ranks its sample against the others in parallel, and then
// the merge stage, which picks the middle ranks and adds them. A result held by a
// stalled output keeps the merge stage full; the lane stage still takes one more
// word, and the input stalls once both stages hold a word.
// Write the stack count only while no word is in flight.
module median_of_samples #(
    parameter int MAX_STACKS  = mos_pkg::DEF_MAX_STACKS,
    parameter int SAMPLE_BITS = mos_pkg::DEF_SAMPLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mos_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [SAMPLE_BITS-1:0]       i_sample_a,
    input  logic [SAMPLE_BITS-1:0]       i_sample_b,
    input  logic [SAMPLE_BITS-1:0]       i_sample_c,
    input  logic [SAMPLE_BITS-1:0]       i_sample_d,
    input  logic [SAMPLE_BITS-1:0]       i_sample_e,
    input  logic [SAMPLE_BITS-1:0]       i_sample_f,
    input  logic [SAMPLE_BITS-1:0]       i_sample_g,
    input  logic [SAMPLE_BITS-1:0]       i_sample_h,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [SAMPLE_BITS:0]         o_median_value
);

    localparam int LANES = (MAX_STACKS < mos_pkg::FIELD_COUNT) ?
                           MAX_STACKS : mos_pkg::FIELD_COUNT;
    localparam int CNT_W = $clog2(LANES + 1);

    logic [mos_pkg::CFG_BITS-1:0] r_stack_count;
    logic                         r_s1_valid;
    logic                         r_out_valid;

    logic [SAMPLE_BITS-1:0] w_samples [mos_pkg::FIELD_COUNT];
    logic [CNT_W-1:0]       w_count;
    logic [CNT_W-1:0]       w_rank  [LANES];
    logic [SAMPLE_BITS-1:0] w_value [LANES];
    logic [LANES-1:0]       w_used;
    logic                   w_s1_ready;
    logic                   w_s2_load;

    assign w_samples[0] = i_sample_a;
    assign w_samples[1] = i_sample_b;
    assign w_samples[2] = i_sample_c;
    assign w_samples[3] = i_sample_d;
    assign w_samples[4] = i_sample_e;
    assign w_samples[5] = i_sample_f;
    assign w_samples[6] = i_sample_g;
    assign w_samples[7] = i_sample_h;

    // Counts above the lane count saturate.
    assign w_count = (r_stack_count > mos_pkg::CFG_BITS'(LANES)) ?
                     CNT_W'(LANES) : r_stack_count[CNT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stack_count <= mos_pkg::STACK_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_stack_count <= i_cfg_data;
        end
    end

    // Each stage moves whenever the one after it is empty or moving.
    assign w_s2_load  = !r_out_valid || !i_stall;
    assign w_s1_ready = !r_s1_valid || w_s2_load;
    assign o_stall    = !w_s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (w_s2_load) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        mos_lane #(
            .LANES       (LANES),
            .LANE_IDX    (g),
            .SAMPLE_BITS (SAMPLE_BITS),
            .CNT_W       (CNT_W)
        ) u_lane (
            .i_clk     (i_clk),
            .i_en      (i_valid && w_s1_ready),
            .i_samples (w_samples),
            .i_count   (w_count),
            .o_rank    (w_rank[g]),
            .o_value   (w_value[g]),
            .o_used    (w_used[g])
        );
    end

    mos_merge #(
        .LANES       (LANES),
        .SAMPLE_BITS (SAMPLE_BITS),
        .CNT_W       (CNT_W)
    ) u_merge (
        .i_clk    (i_clk),
        .i_en     (r_s1_valid && w_s2_load),
        .i_count  (w_count),
        .i_rank   (w_rank),
        .i_value  (w_value),
        .i_used   (w_used),
        .o_median (o_median_value)
    );

    assign o_valid = r_out_valid;

`ifndef SYNTHESIS
    // The input side stalls only when the lane stage holds a word that cannot move.
    a_stall_needs_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked lane stage");

    // A word leaving the lane stage shows up as a result in the next cycle.
    a_s1_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_s2_load) |=> r_out_valid)
        else $error("lane stage word lost on its way to the output");

    // A count of zero always yields a zero median.
    a_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && w_s2_load && w_count == '0) |=> (o_median_value == '0))
        else $error("nonzero median with no stacks in use");
`endif

endmodule
